/* rtl/utf8_checked_line_splitter_unit_defines.svh */
// Assertion macros for the line splitter.
`ifndef UTF8_CHECKED_LINE_SPLITTER_UNIT_DEFINES_SVH
`define UTF8_CHECKED_LINE_SPLITTER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define UCLS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");
`define UCLS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define UCLS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define UCLS_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

/* rtl/ucls_pkg.sv */
package ucls_pkg;

	localparam longint unsigned MAX_SEGMENT_LEN = 65535;
	localparam logic [15:0] LEN_CAP =
		(MAX_SEGMENT_LEN > 64'd65535) ? 16'hFFFF : 16'(MAX_SEGMENT_LEN);

	localparam logic [7:0] CHAR_LF = 8'd10;
	localparam logic [7:0] CHAR_CR = 8'd13;

	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
	localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_buffer;
	} in_item_t;

	typedef struct packed {
		logic        segment_valid;
		logic [15:0] segment_length;
		logic        segment_is_final;
		logic        ended_with_newline;
		logic        split_stopped;
		logic        last_of_run;
	} out_item_t;

	typedef struct packed {
		logic [1:0] num;
		out_item_t  first;
		out_item_t  second;
	} res_pair_t;

endpackage

/* rtl/utf8_checked_line_splitter_unit.sv */
// UTF-8 checked line splitter. Takes one text byte per transfer, with
// end_of_buffer on the last byte of a buffer, and returns a result for each
// LF (line length without the LF and a CR just before it) and one final
// result on the last byte. An LF on the last byte gives two results in a row.
// Bytes are taken at one per cycle unless the input stalls; a byte is
// registered, then, once the queue has room, updates the splitter state
// and writes its results into a four-entry output queue. Input stalls
// only while a registered byte waits for queue room. After invalid UTF-8
// the rest of the buffer counts into the final segment.
`include "utf8_checked_line_splitter_unit_defines.svh"

module utf8_checked_line_splitter_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                text_valid,
	output logic                text_stall,
	input  ucls_pkg::in_item_t  text,
	output logic                result_valid,
	input  logic                result_stall,
	output ucls_pkg::out_item_t result
);

	logic                       in_valid_s1;
	ucls_pkg::in_item_t         in_item_s1;
	logic                       room;
	logic                       step;
	logic                       pop;
	logic [ucls_pkg::CNT_W-1:0] fifo_count;
	ucls_pkg::res_pair_t        res;

	assign step       = in_valid_s1 && room;
	assign text_stall = in_valid_s1 && !room;
	assign pop        = result_valid && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (!text_stall) begin
			in_valid_s1 <= text_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!text_stall && text_valid) begin
			in_item_s1 <= text;
		end
	end

	ucls_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (in_item_s1),
		.res    (res)
	);

	ucls_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res),
		.pop       (pop),
		.not_empty (result_valid),
		.room      (room),
		.count     (fifo_count),
		.head      (result)
	);

	`UCLS_ASSERT_IMP(a_result_marked, clk, arst_n, result_valid, result.segment_valid)
	`UCLS_ASSERT_IMP(a_final_is_last, clk, arst_n, result_valid && result.segment_is_final, result.last_of_run)
	`UCLS_ASSERT_NXT(a_s1_held, clk, arst_n, text_stall, in_valid_s1 && $stable(in_item_s1))
	`UCLS_ASSERT_IMP(a_fifo_bound, clk, arst_n, 1'b1, fifo_count <= ucls_pkg::CNT_W'(ucls_pkg::FIFO_DEPTH))

endmodule

/* rtl/ucls_core.sv */
module ucls_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  ucls_pkg::in_item_t  item,
	output ucls_pkg::res_pair_t res
);

	logic [1:0]  pend_q, pend_n;
	logic        cr_q, cr_n;
	logic        stop_q, stop_n;
	logic [15:0] cnt_q, cnt_n;
	logic        line_end;
	logic [15:0] line_len;
	ucls_pkg::out_item_t line_res, fin_res;

	function automatic logic [15:0] sat_add(logic [15:0] a, logic [1:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {15'd0, b};
		return (s > {1'b0, ucls_pkg::LEN_CAP}) ? ucls_pkg::LEN_CAP : s[15:0];
	endfunction

	always_comb begin
		pend_n   = pend_q;
		cr_n     = cr_q;
		stop_n   = stop_q;
		cnt_n    = cnt_q;
		line_end = 1'b0;
		line_len = 16'd0;
		if (stop_q) begin
			cnt_n = sat_add(cnt_q, 2'd1);
		end else if (pend_q != 2'd0) begin
			if (item.text_byte inside {[8'h80:8'hBF]}) begin
				pend_n = pend_q - 2'd1;
			end else begin
				stop_n = 1'b1;
			end
			cnt_n = sat_add(cnt_q, 2'd1);
		end else if (item.text_byte == ucls_pkg::CHAR_LF) begin
			line_end = 1'b1;
			line_len = cnt_q;
			cnt_n    = 16'd0;
			cr_n     = 1'b0;
		end else if (item.text_byte == ucls_pkg::CHAR_CR) begin
			cnt_n = sat_add(cnt_q, {1'b0, cr_q});
			cr_n  = 1'b1;
		end else begin
			cnt_n = sat_add(cnt_q, 2'd1 + {1'b0, cr_q});
			cr_n  = 1'b0;
			if (item.text_byte inside {[8'h00:8'h7F]}) begin
				pend_n = 2'd0;
			end else if (item.text_byte inside {[8'hC0:8'hDF]}) begin
				pend_n = 2'd1;
			end else if (item.text_byte inside {[8'hE0:8'hEF]}) begin
				pend_n = 2'd2;
			end else if (item.text_byte inside {[8'hF0:8'hF7]}) begin
				pend_n = 2'd3;
			end else begin
				stop_n = 1'b1;
			end
		end

		line_res.segment_valid      = 1'b1;
		line_res.segment_length     = line_len;
		line_res.segment_is_final   = 1'b0;
		line_res.ended_with_newline = 1'b0;
		line_res.split_stopped      = 1'b0;
		line_res.last_of_run        = !item.end_of_buffer;

		fin_res.segment_valid      = 1'b1;
		fin_res.segment_length     = sat_add(cnt_n, {1'b0, cr_n});
		fin_res.segment_is_final   = 1'b1;
		fin_res.ended_with_newline = line_end && !stop_n;
		fin_res.split_stopped      = stop_n;
		fin_res.last_of_run        = 1'b1;

		res.first  = line_end ? line_res : fin_res;
		res.second = fin_res;
		if (!step) begin
			res.num = 2'd0;
		end else begin
			res.num = {1'b0, line_end} + {1'b0, item.end_of_buffer};
		end

		if (item.end_of_buffer) begin
			pend_n = 2'd0;
			cr_n   = 1'b0;
			stop_n = 1'b0;
			cnt_n  = 16'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 2'd0;
			cr_q   <= 1'b0;
			stop_q <= 1'b0;
			cnt_q  <= 16'd0;
		end else if (step) begin
			pend_q <= pend_n;
			cr_q   <= cr_n;
			stop_q <= stop_n;
			cnt_q  <= cnt_n;
		end
	end

endmodule

/* rtl/ucls_fifo.sv */
module ucls_fifo (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ucls_pkg::res_pair_t               push,
	input  logic                              pop,
	output logic                              not_empty,
	output logic                              room,
	output logic [ucls_pkg::CNT_W-1:0]        count,
	output ucls_pkg::out_item_t               head
);

	ucls_pkg::out_item_t mem_q [ucls_pkg::FIFO_DEPTH];
	logic [ucls_pkg::PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [ucls_pkg::CNT_W-1:0] count_q;

	assign not_empty = count_q != '0;
	assign room      = count_q <= ucls_pkg::CNT_W'(ucls_pkg::FIFO_DEPTH - 2);
	assign count     = count_q;
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.num != 2'd0) begin
			mem_q[wr_ptr_q] <= push.first;
		end
		if (push.num == 2'd2) begin
			mem_q[wr_ptr_q + ucls_pkg::PTR_W'(1)] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + ucls_pkg::PTR_W'(push.num);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + ucls_pkg::PTR_W'(1);
			end
			count_q <= count_q + ucls_pkg::CNT_W'(push.num) - ucls_pkg::CNT_W'(pop);
		end
	end

endmodule
